// ===== sv/kls_pkg.sv =====
// ============================================================================
// kls_pkg
// Shared types, codes and defaults for the keyed latency statistics table.
// ============================================================================
package kls_pkg;

    // Default sizes
    localparam int TABLE_DEPTH_DEF = 64;
    localparam int KEY_BITS_DEF    = 64;
    localparam int SLOT_W_MAX      = 10;

    // Register reset values
    localparam logic [31:0] LOW_THR_RST  = 32'd100000;
    localparam logic [31:0] MID_THR_RST  = 32'd500000;
    localparam logic [31:0] HIGH_THR_RST = 32'd1000000;
    localparam logic [31:0] OK_CODE_RST  = 32'd0;

    // Register indexes
    localparam logic [1:0] REG_LOW_THR  = 2'd0;
    localparam logic [1:0] REG_MID_THR  = 2'd1;
    localparam logic [1:0] REG_HIGH_THR = 2'd2;
    localparam logic [1:0] REG_OK_CODE  = 2'd3;

    // Request codes
    localparam logic [1:0] REQ_ADD   = 2'd0;
    localparam logic [1:0] REQ_QUERY = 2'd1;
    localparam logic [1:0] REQ_CLEAR = 2'd2;

    // Status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;

    // Back-end operations
    localparam logic [1:0] OP_UPDATE = 2'd0;
    localparam logic [1:0] OP_READ   = 2'd1;
    localparam logic [1:0] OP_REPLY  = 2'd2;

    typedef struct packed {
        logic [1:0]         req_type;
        logic [63:0]        type_key;
        logic signed [31:0] result_code;
        logic [15:0]        weight;
        logic               times_present;
        logic [47:0]        begin_time_us;
        logic [47:0]        end_time_us;
        logic               tag_present;
        logic [31:0]        record_tag;
    } t_req;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] all_count;
        logic [31:0] failed_count;
        logic [63:0] total_time_us;
        logic [31:0] max_time_us;
        logic [31:0] min_time_us;
        logic [31:0] bucket_low_count;
        logic [31:0] bucket_mid_count;
        logic [31:0] bucket_high_count;
        logic [31:0] tag_at_max;
    } t_res;

    typedef struct packed {
        logic [31:0] all_cnt;
        logic [31:0] fail_cnt;
        logic [63:0] total;
        logic [31:0] max_us;
        logic [31:0] min_us;
        logic [31:0] b_low;
        logic [31:0] b_mid;
        logic [31:0] b_high;
        logic [31:0] max_tag;
    } t_rec;

    // Classified command from front to back
    typedef struct packed {
        logic [1:0]            op;
        logic [1:0]            status;
        logic                  fresh;
        logic [SLOT_W_MAX-1:0] slot;
        logic                  failed;
        logic [15:0]           weight;
        logic                  times_present;
        logic [63:0]           diff;
        logic                  tag_present;
        logic [31:0]           tag;
    } t_cmd;

    typedef struct packed {
        logic [31:0] low_thr;
        logic [31:0] mid_thr;
        logic [31:0] high_thr;
        logic [31:0] ok_code;
    } t_cfg;

endpackage

// ===== sv/keyed_latency_stats_table.sv =====
// ============================================================================
// keyed_latency_stats_table
// Per-key latency statistics: counts, span buckets, min/max/total per record.
// ============================================================================
// Usage:
//   Requests enter on a queue-style port: i_req is taken when push is high
//   and full is low. Results leave the same way: o_res holds the oldest
//   result while empty is low, and it is taken when pop is high.
//   Thresholds and the OK code sit behind an APB port (4 registers at 4*i).
// Flow:
//   The front matches keys in a register CAM in the cycle of acceptance and
//   queues a command (two-entry queue). The back pops a command and reads
//   the record memory in its idle state, then writes the record back and
//   fills the result register in its execute state; it takes no new command
//   until that is done and the result register is free or being taken.
// Reset:
//   Synchronous, active low. Empties the table and restores register
//   defaults; record memory needs no clearing since inserts start clean.
// Stall:
//   While pop stays low the result is held, the back stops, the command
//   queue fills and full rises.
module keyed_latency_stats_table #(
    parameter int TABLE_DEPTH = kls_pkg::TABLE_DEPTH_DEF,
    parameter int KEY_BITS    = kls_pkg::KEY_BITS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          push,
    output logic          full,
    input  kls_pkg::t_req i_req,
    output logic          empty,
    input  logic          pop,
    output kls_pkg::t_res o_res,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [3:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready
);
    import kls_pkg::*;

    t_cfg r_cfg;
    t_cmd front_cmd, q_cmd;
    logic accept, q_empty, q_pop;
    logic [1:0] reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];
    assign accept  = push && !full;

    // Register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.low_thr  <= LOW_THR_RST;
            r_cfg.mid_thr  <= MID_THR_RST;
            r_cfg.high_thr <= HIGH_THR_RST;
            r_cfg.ok_code  <= OK_CODE_RST;
        end else if (psel && penable && pwrite) begin
            case (reg_idx)
                REG_LOW_THR:  r_cfg.low_thr  <= pwdata;
                REG_MID_THR:  r_cfg.mid_thr  <= pwdata;
                REG_HIGH_THR: r_cfg.high_thr <= pwdata;
                REG_OK_CODE:  r_cfg.ok_code  <= pwdata;
                default: ;
            endcase
        end
    end

    // Register reads
    always_comb begin
        case (reg_idx)
            REG_LOW_THR:  prdata = r_cfg.low_thr;
            REG_MID_THR:  prdata = r_cfg.mid_thr;
            REG_HIGH_THR: prdata = r_cfg.high_thr;
            REG_OK_CODE:  prdata = r_cfg.ok_code;
            default:      prdata = '0;
        endcase
    end

    kls_front #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .KEY_BITS    (KEY_BITS)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_req    (i_req),
        .i_cfg    (r_cfg),
        .o_cmd    (front_cmd)
    );

    kls_cmd_fifo u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (accept),
        .i_data  (front_cmd),
        .o_full  (full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_data  (q_cmd)
    );

    kls_back #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_cmd_empty (q_empty),
        .i_cmd       (q_cmd),
        .o_cmd_pop   (q_pop),
        .o_empty     (empty),
        .i_pop       (pop),
        .o_res       (o_res)
    );
endmodule

// ===== sv/kls_ram.sv =====
// ============================================================================
// kls_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ============================================================================
module kls_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// ===== sv/kls_front.sv =====
// ============================================================================
// kls_front
// Key CAM: looks keys up, allocates slots, clears the table, classifies items.
// ============================================================================
module kls_front #(
    parameter int TABLE_DEPTH = 64,
    parameter int KEY_BITS    = 64
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_accept,
    input  kls_pkg::t_req i_req,
    input  kls_pkg::t_cfg i_cfg,
    output kls_pkg::t_cmd o_cmd
);
    import kls_pkg::*;

    localparam int SW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    logic [KEY_BITS-1:0] r_key [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] r_valid, n_valid;
    logic [CW-1:0] r_used, n_used;

    logic [KEY_BITS-1:0] key;
    logic                hit;
    logic [SW-1:0]       hit_idx;
    logic                tbl_full;
    logic [SW-1:0]       new_idx;
    logic [48:0]         diff49;
    logic                ins;

    assign key      = i_req.type_key[KEY_BITS-1:0];
    assign tbl_full = (r_used == CW'(TABLE_DEPTH));
    assign new_idx  = r_used[SW-1:0];
    assign diff49   = {1'b0, i_req.end_time_us} - {1'b0, i_req.begin_time_us};

    // Parallel key match; keys are unique so an OR of indexes suffices
    always_comb begin
        hit     = 1'b0;
        hit_idx = '0;
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            if (r_valid[i] && r_key[i] == key) begin
                hit     = 1'b1;
                hit_idx = hit_idx | SW'(i);
            end
        end
    end

    // Classify the item
    always_comb begin
        o_cmd               = '0;
        o_cmd.failed        = (i_req.result_code != i_cfg.ok_code);
        o_cmd.weight        = i_req.weight;
        o_cmd.times_present = i_req.times_present;
        o_cmd.diff          = {{15{diff49[48]}}, diff49};
        o_cmd.tag_present   = i_req.tag_present;
        o_cmd.tag           = i_req.record_tag;
        o_cmd.op            = OP_REPLY;
        o_cmd.status        = ST_OK;
        ins                 = 1'b0;
        case (i_req.req_type)
            REQ_ADD: begin
                if (hit) begin
                    o_cmd.op   = OP_UPDATE;
                    o_cmd.slot = SLOT_W_MAX'(hit_idx);
                end else if (tbl_full) begin
                    o_cmd.status = ST_FULL;
                end else begin
                    o_cmd.op    = OP_UPDATE;
                    o_cmd.fresh = 1'b1;
                    o_cmd.slot  = SLOT_W_MAX'(new_idx);
                    ins         = 1'b1;
                end
            end
            REQ_QUERY: begin
                if (hit) begin
                    o_cmd.op   = OP_READ;
                    o_cmd.slot = SLOT_W_MAX'(hit_idx);
                end else begin
                    o_cmd.status = ST_NOT_FOUND;
                end
            end
            default: ;
        endcase
    end

    // Next table occupancy
    always_comb begin
        n_valid = r_valid;
        n_used  = r_used;
        if (i_accept) begin
            if (i_req.req_type == REQ_CLEAR) begin
                n_valid = '0;
                n_used  = '0;
            end else if (ins) begin
                n_valid[new_idx] = 1'b1;
                n_used           = r_used + CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_used  <= '0;
        end else begin
            r_valid <= n_valid;
            r_used  <= n_used;
        end
    end

    // Store the key of a newly inserted slot
    always_ff @(posedge i_clk) begin
        if (i_accept && ins) begin
            r_key[new_idx] <= key;
        end
    end

`ifndef ASSERT_OFF
    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= CW'(TABLE_DEPTH))
        else $error("used count beyond table depth");
    a_used_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_valid) == int'(r_used))
        else $error("valid bits disagree with used count");
    a_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_accept && i_req.req_type == REQ_CLEAR |=> r_used == '0)
        else $error("clear did not empty the table");
`endif
endmodule

// ===== sv/kls_cmd_fifo.sv =====
// ============================================================================
// kls_cmd_fifo
// Two-entry queue of classified commands between front and back.
// ============================================================================
module kls_cmd_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  kls_pkg::t_cmd i_data,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_empty,
    output kls_pkg::t_cmd o_data
);
    import kls_pkg::*;

    t_cmd       r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_data  = r_mem[r_rp];

    // Advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end
endmodule

// ===== sv/kls_back.sv =====
// ============================================================================
// kls_back
// Record read-modify-write engine and result register.
// ============================================================================
module kls_back #(
    parameter int TABLE_DEPTH = 64
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  kls_pkg::t_cfg i_cfg,
    input  logic          i_cmd_empty,
    input  kls_pkg::t_cmd i_cmd,
    output logic          o_cmd_pop,
    output logic          o_empty,
    input  logic          i_pop,
    output kls_pkg::t_res o_res
);
    import kls_pkg::*;

    localparam int SW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } t_state;

    t_state r_state, n_state;
    t_cmd   r_cmd;
    t_res   r_out, n_out;
    logic   r_out_valid;
    t_rec   rdata, base, upd;
    logic   we;
    logic [31:0] span;

    assign o_cmd_pop = (r_state == S_IDLE) && !i_cmd_empty && (!r_out_valid || i_pop);
    assign o_empty   = !r_out_valid;
    assign o_res     = r_out;
    assign we        = (r_state == S_EXEC) && (r_cmd.op == OP_UPDATE);

    kls_ram #(
        .WIDTH ($bits(t_rec)),
        .DEPTH (TABLE_DEPTH)
    ) u_rec_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (r_cmd.slot[SW-1:0]),
        .i_wdata (upd),
        .i_raddr (i_cmd.slot[SW-1:0]),
        .o_rdata (rdata)
    );

    // Apply one sample to the record
    always_comb begin
        base = r_cmd.fresh ? '0 : rdata;
        upd  = base;
        span = r_cmd.diff[31:0];
        upd.all_cnt = base.all_cnt + 32'(r_cmd.weight);
        if (r_cmd.failed) begin
            upd.fail_cnt = base.fail_cnt + 32'(r_cmd.weight);
        end
        if (r_cmd.times_present) begin
            if (span >= i_cfg.low_thr && span < i_cfg.mid_thr) begin
                upd.b_low = base.b_low + 32'd1;
            end else if (span >= i_cfg.mid_thr && span < i_cfg.high_thr) begin
                upd.b_mid = base.b_mid + 32'd1;
            end else if (span >= i_cfg.high_thr) begin
                upd.b_high = base.b_high + 32'd1;
            end
            if (span > base.max_us) begin
                upd.max_us = span;
                if (r_cmd.tag_present) begin
                    upd.max_tag = r_cmd.tag;
                end
            end
            if (base.min_us == 32'd0 || span < base.min_us) begin
                upd.min_us = span;
            end
            upd.total = base.total + r_cmd.diff;
        end
    end

    // Build the result
    always_comb begin
        n_out        = '0;
        n_out.status = r_cmd.status;
        if (r_cmd.op == OP_READ) begin
            n_out.all_count         = rdata.all_cnt;
            n_out.failed_count      = rdata.fail_cnt;
            n_out.total_time_us     = rdata.total;
            n_out.max_time_us       = rdata.max_us;
            n_out.min_time_us       = rdata.min_us;
            n_out.bucket_low_count  = rdata.b_low;
            n_out.bucket_mid_count  = rdata.b_mid;
            n_out.bucket_high_count = rdata.b_high;
            n_out.tag_at_max        = rdata.max_tag;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (o_cmd_pop) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // Sequence and hold the result until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_EXEC) begin
                r_out_valid <= 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_cmd_pop) begin
            r_cmd <= i_cmd;
        end
        if (r_state == S_EXEC) begin
            r_out <= n_out;
        end
    end

`ifndef ASSERT_OFF
    a_exec_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_EXEC |=> r_state == S_IDLE)
        else $error("exec state held");
    a_out_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_EXEC))
        else $error("result appeared without execution");
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_EXEC |-> !r_out_valid)
        else $error("result register overrun");
`endif
endmodule
